// ===== rtl/aabb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared widths, command codes, box type and sequencer states of the
// box table overlap scanner.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int POS_W     = 24;           // signed Q15.8 position
    localparam int SIZE_W    = 15;           // size in whole units
    localparam int FRAC_W    = 8;            // fraction bits of a position
    localparam int SUM_W     = POS_W + 2;    // exact edge sum width
    localparam int CMD_W     = 2;
    localparam int OUT_IDX_W = 6;            // width of skip_index and hit_index

    localparam int DEF_MAX_BOXES = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic        [SIZE_W-1:0] w;
        logic        [SIZE_W-1:0] h;
    } t_box;

endpackage

// ===== rtl/aabb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_in_if / aabb_out_if
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface aabb_in_if;
    import aabb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [POS_W-1:0]    box_x;
    logic signed [POS_W-1:0]    box_y;
    logic [SIZE_W-1:0]          box_width;
    logic [SIZE_W-1:0]          box_height;
    logic                       skip_valid;
    logic [OUT_IDX_W-1:0]       skip_index;

    modport source (
        output valid, command, box_x, box_y, box_width, box_height,
               skip_valid, skip_index,
        input  ready
    );
    modport sink (
        input  valid, command, box_x, box_y, box_width, box_height,
               skip_valid, skip_index,
        output ready
    );
endinterface

interface aabb_out_if;
    import aabb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [OUT_IDX_W-1:0]       hit_index;
    logic                       status;

    modport source (output valid, hit, hit_index, status, input ready);
    modport sink   (input  valid, hit, hit_index, status, output ready);
endinterface

// ===== rtl/aabb_box_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_box_mem
// Box table: corner and extent stores, one write port, one registered read.
// ----------------------------------------------------------------------------
module aabb_box_mem #(
    parameter int MAX_BOXES = aabb_pkg::DEF_MAX_BOXES,
    parameter int IDX_W     = $clog2(MAX_BOXES)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  aabb_pkg::t_box      i_wr_box,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output aabb_pkg::t_box      o_rd_box
);
    import aabb_pkg::*;

    logic [2*POS_W-1:0]  r_corner [MAX_BOXES];
    logic [2*SIZE_W-1:0] r_extent [MAX_BOXES];
    logic [2*POS_W-1:0]  r_rd_corner;
    logic [2*SIZE_W-1:0] r_rd_extent;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_corner[i_wr_addr] <= {i_wr_box.y, i_wr_box.x};
            r_extent[i_wr_addr] <= {i_wr_box.h, i_wr_box.w};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_corner <= r_corner[i_rd_addr];
        r_rd_extent <= r_extent[i_rd_addr];
    end

    assign o_rd_box.x = r_rd_corner[POS_W-1:0];
    assign o_rd_box.y = r_rd_corner[2*POS_W-1:POS_W];
    assign o_rd_box.w = r_rd_extent[SIZE_W-1:0];
    assign o_rd_box.h = r_rd_extent[2*SIZE_W-1:SIZE_W];

endmodule

// ===== rtl/aabb_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_cmp
// Shared overlap unit: strict overlap of two boxes on both axes.
// ----------------------------------------------------------------------------
module aabb_cmp (
    input  aabb_pkg::t_box  i_a,
    input  aabb_pkg::t_box  i_b,
    output logic            o_overlap
);
    import aabb_pkg::*;

    logic signed [SUM_W-1:0] ax, ay, bx, by;
    logic signed [SUM_W-1:0] aw, ah, bw, bh;

    // sizes go to Q15.8 by appending the fraction bits
    assign ax = SUM_W'(i_a.x);
    assign ay = SUM_W'(i_a.y);
    assign bx = SUM_W'(i_b.x);
    assign by = SUM_W'(i_b.y);
    assign aw = signed'({{(SUM_W-SIZE_W-FRAC_W){1'b0}}, i_a.w, {FRAC_W{1'b0}}});
    assign ah = signed'({{(SUM_W-SIZE_W-FRAC_W){1'b0}}, i_a.h, {FRAC_W{1'b0}}});
    assign bw = signed'({{(SUM_W-SIZE_W-FRAC_W){1'b0}}, i_b.w, {FRAC_W{1'b0}}});
    assign bh = signed'({{(SUM_W-SIZE_W-FRAC_W){1'b0}}, i_b.h, {FRAC_W{1'b0}}});

    assign o_overlap = (ax < bx + bw) && (ay < by + bh) &&
                       (ax + aw > bx) && (ay + ah > by);

endmodule

// ===== rtl/aabb_overlap_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_overlap_scan
// Box table with append, clear and strict-overlap query over stored boxes.
// ----------------------------------------------------------------------------
// Usage: every command transaction yields exactly one result transaction.
// Append and clear go straight to the done state, which moves the result
// into the output register once that register is free; the next command
// is taken after that. A query walks the table through one shared overlap
// unit, one stored entry per cycle from index 0 up to the last entry below
// the fill count, behind the registered read of the box memory, and then
// passes through the done state in the same way. The input side is not
// ready while a command is in progress; the result sits in an output
// register, so the next command is accepted while a result still waits to
// be taken. The table itself needs no clearing: only entries below the
// fill count are ever checked, and those were all written by appends.
// ----------------------------------------------------------------------------
module aabb_overlap_scan #(
    parameter int MAX_BOXES = aabb_pkg::DEF_MAX_BOXES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    aabb_in_if.sink             i_cmd,
    aabb_out_if.source          o_res
);
    import aabb_pkg::*;

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    // common width for index compares against the 6-bit skip index
    localparam int CMP_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;     // fill count
    logic [CNT_W-1:0]       r_scan,  n_scan;      // next entry to read
    logic                   r_pipe_valid, n_pipe_valid;
    logic [IDX_W-1:0]       r_pipe_idx,   n_pipe_idx;   // entry on memory output
    t_box                   r_query, n_query;
    logic                   r_skip_valid, n_skip_valid;
    logic [OUT_IDX_W-1:0]   r_skip_idx,   n_skip_idx;
    logic                   r_hit, n_hit;
    logic [OUT_IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic                   r_status, n_status;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_hit, n_out_hit;
    logic [OUT_IDX_W-1:0]   r_out_hit_idx, n_out_hit_idx;
    logic                   r_out_status, n_out_status;

    logic                   mem_we;
    t_box                   in_box;
    t_box                   rd_box;
    logic                   overlap;
    logic                   skip_match;
    logic [CMP_W-1:0]       pipe_idx_ext;

    assign in_box.x = i_cmd.box_x;
    assign in_box.y = i_cmd.box_y;
    assign in_box.w = i_cmd.box_width;
    assign in_box.h = i_cmd.box_height;

    aabb_box_mem #(
        .MAX_BOXES (MAX_BOXES),
        .IDX_W     (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_box  (in_box),
        .i_rd_addr (r_scan[IDX_W-1:0]),
        .o_rd_box  (rd_box)
    );

    aabb_cmp u_cmp (
        .i_a       (r_query),
        .i_b       (rd_box),
        .o_overlap (overlap)
    );

    // skip index beyond the fill count never matches a scanned entry
    assign pipe_idx_ext = CMP_W'(r_pipe_idx);
    assign skip_match   = r_skip_valid && (pipe_idx_ext == CMP_W'(r_skip_idx));

    assign i_cmd.ready     = (r_state == ST_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.hit       = r_out_hit;
    assign o_res.hit_index = r_out_hit_idx;
    assign o_res.status    = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_pipe_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pipe_valid <= n_pipe_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan        <= n_scan;
        r_pipe_idx    <= n_pipe_idx;
        r_query       <= n_query;
        r_skip_valid  <= n_skip_valid;
        r_skip_idx    <= n_skip_idx;
        r_hit         <= n_hit;
        r_hit_idx     <= n_hit_idx;
        r_status      <= n_status;
        r_out_hit     <= n_out_hit;
        r_out_hit_idx <= n_out_hit_idx;
        r_out_status  <= n_out_status;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_scan        = r_scan;
        n_pipe_valid  = 1'b0;
        n_pipe_idx    = r_scan[IDX_W-1:0];
        n_query       = r_query;
        n_skip_valid  = r_skip_valid;
        n_skip_idx    = r_skip_idx;
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_status      = r_status;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_hit     = r_out_hit;
        n_out_hit_idx = r_out_hit_idx;
        n_out_status  = r_out_status;
        mem_we        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_query      = in_box;
                    n_skip_valid = i_cmd.skip_valid;
                    n_skip_idx   = i_cmd.skip_index;
                    n_hit        = 1'b0;
                    n_hit_idx    = '0;
                    n_status     = 1'b0;
                    n_scan       = '0;
                    n_state      = ST_DONE;
                    case (i_cmd.command)
                        CMD_APPEND: begin
                            if (r_count < CNT_W'(MAX_BOXES)) begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_status = 1'b1;    // table full
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_QUERY: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            // unused code: table untouched, null result
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_scan < r_count) begin
                    n_pipe_valid = 1'b1;
                    n_scan       = r_scan + 1'b1;
                end else begin
                    // last read (if any) is being checked this cycle
                    n_state = ST_DONE;
                end
                // ascending scan: the last hit is the highest index
                if (r_pipe_valid && overlap && !skip_match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = pipe_idx_ext[OUT_IDX_W-1:0];
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_hit     = r_hit;
                    n_out_hit_idx = r_hit_idx;
                    n_out_status  = r_status;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // fill count never passes the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BOXES))
        else $error("fill count beyond table depth");

    // memory reads only in flight during a scan
    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_valid |-> (r_state == ST_SCAN))
        else $error("entry read outside of a scan");

    // a miss reports index zero
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_hit_idx == '0))
        else $error("nonzero hit index without hit");

    // a refused append never reports a hit
    a_status_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> !r_out_hit)
        else $error("hit reported with full-table status");

    // table stays untouched while a scan runs
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> (r_count == $past(r_count)))
        else $error("fill count changed during scan");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box table overlap scanner. Command transactions
// (append, clear, query, plus the unused code) come from a backlog filled up
// front: a directed opening, a fill past the top, then random episodes of
// clear, appends and queries. A shadow copy of the table works out each
// expected result when a command is accepted, and the result monitor checks
// every result field by field. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import aabb_pkg::*;

    localparam int MAX_BOXES = DEF_MAX_BOXES;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // no-op command code
    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = MAX_BOXES + 16;     // full-table query + margin

    typedef struct {
        logic [CMD_W-1:0]     command;
        t_box                 box;
        logic                 skip_valid;
        logic [OUT_IDX_W-1:0] skip_index;
        bit                   wait_idle;   // hold until all results are back
    } t_scan_cmd;

    typedef struct packed {
        logic                 hit;
        logic [OUT_IDX_W-1:0] hit_index;
        logic                 status;
    } t_scan_res;

    logic i_clk;
    logic i_rst_n;

    aabb_in_if  cmd_if ();
    aabb_out_if res_if ();

    aabb_overlap_scan #(
        .MAX_BOXES (MAX_BOXES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Stimulus backlog, expected results, and the shadow table.
    t_scan_cmd cmd_backlog[$];
    t_scan_res expected_results[$];
    t_box      shadow_box [MAX_BOXES];
    int        shadow_count;

    t_scan_cmd cur_cmd;
    int        send_gap;
    int        recv_stall;
    int        n_accepted;
    int        n_checked;
    int        n_fail;

    // ------------------------------------------------------------------------
    // Clock, reset, and known values on every input from time zero.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = '0;
        cmd_if.box_x       = '0;
        cmd_if.box_y       = '0;
        cmd_if.box_width   = '0;
        cmd_if.box_height  = '0;
        cmd_if.skip_valid  = 1'b0;
        cmd_if.skip_index  = '0;
        res_if.ready       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Failure bookkeeping: the first ten get a line, the rest are counted.
    // ------------------------------------------------------------------------
    function automatic void note_failure(string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Shadow model. Strict overlap on both axes, sizes scaled to Q15.8,
    // evaluated in 64 bits so no edge sum can wrap.
    // ------------------------------------------------------------------------
    function automatic bit boxes_cross(t_box a, t_box b);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        ax = $signed(a.x);
        ay = $signed(a.y);
        aw = longint'(a.w) << FRAC_W;
        ah = longint'(a.h) << FRAC_W;
        bx = $signed(b.x);
        by = $signed(b.y);
        bw = longint'(b.w) << FRAC_W;
        bh = longint'(b.h) << FRAC_W;
        return (ax < bx + bw) && (ay < by + bh) && (ax + aw > bx) && (ay + ah > by);
    endfunction

    // Applies one accepted command to the shadow table and queues its result.
    function automatic void predict_scan_result(t_scan_cmd c);
        t_scan_res r;
        r = '0;
        case (c.command)
            CMD_APPEND: begin
                if (shadow_count < MAX_BOXES) begin
                    shadow_box[shadow_count] = c.box;
                    shadow_count++;
                end else begin
                    r.status = 1'b1;      // table full, nothing stored
                end
            end
            CMD_CLEAR: begin
                shadow_count = 0;
            end
            CMD_QUERY: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (c.skip_valid && i == int'(c.skip_index)) continue;
                    if (boxes_cross(c.box, shadow_box[i])) begin
                        r.hit       = 1'b1;
                        r.hit_index = OUT_IDX_W'(i);   // last hit wins
                    end
                end
            end
            default: ;                    // unused code: no effect, all zero
        endcase
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Pace of either side: quiet stretches with no idling, otherwise 0..3.
    function automatic int draw_pause(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 3));
    endfunction

    // ------------------------------------------------------------------------
    // Command driver. A transaction is taken when valid and ready are high at
    // the edge; the shadow model is updated right there. A command flagged
    // wait_idle is held back until every outstanding result has arrived.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : cmd_driver
        bit fire;
        fire = cmd_if.valid && cmd_if.ready;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap     = 0;
        end else begin
            if (fire) begin
                predict_scan_result(cur_cmd);
                n_accepted++;
                send_gap = draw_pause(((n_accepted / 80) % 4) == 1);
            end
            if (!cmd_if.valid || fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog.size() > 0 &&
                             !(cmd_backlog[0].wait_idle && expected_results.size() > 0)) begin
                    cur_cmd = cmd_backlog.pop_front();
                    cmd_if.valid      <= 1'b1;
                    cmd_if.command    <= cur_cmd.command;
                    cmd_if.box_x      <= cur_cmd.box.x;
                    cmd_if.box_y      <= cur_cmd.box.y;
                    cmd_if.box_width  <= cur_cmd.box.w;
                    cmd_if.box_height <= cur_cmd.box.h;
                    cmd_if.skip_valid <= cur_cmd.skip_valid;
                    cmd_if.skip_index <= cur_cmd.skip_index;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each result transaction is matched against the oldest
    // expectation; ready drops for a random stall after each one.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : res_monitor
        t_scan_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            recv_stall   = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result %0d with nothing expected: hit=%0b idx=%0d st=%0b",
                                           n_checked, res_if.hit, res_if.hit_index,
                                           res_if.status));
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.hit !== want.hit || res_if.hit_index !== want.hit_index ||
                        res_if.status !== want.status) begin
                        note_failure($sformatf(
                            "result %0d: exp hit=%0b idx=%0d st=%0b, got hit=%0b idx=%0d st=%0b",
                            n_checked, want.hit, want.hit_index, want.status,
                            res_if.hit, res_if.hit_index, res_if.status));
                    end
                end
                recv_stall = draw_pause(((n_checked / 60) % 4) == 2);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generation. gen_count tracks the fill level on the generator
    // side so skip indices mostly point at real entries; last_box lets
    // queries land exactly on, or one LSB inside, a stored edge.
    // ------------------------------------------------------------------------
    int   gen_count;
    int   gen_items;
    int   last_hold;
    t_box last_box;

    function automatic void add_cmd(logic [CMD_W-1:0] cmd, t_box b, logic skv = 1'b0,
                                    logic [OUT_IDX_W-1:0] ski = '0, bit hold = 1'b0);
        t_scan_cmd c;
        c.command    = cmd;
        c.box        = b;
        c.skip_valid = skv;
        c.skip_index = ski;
        c.wait_idle  = hold;
        cmd_backlog.insert(cmd_backlog.size(), c);
        if (cmd != CMD_UNUSED) gen_items++;     // no-op commands are not counted
        if (cmd == CMD_CLEAR) gen_count = 0;
        if (cmd == CMD_APPEND) begin
            last_box = b;
            if (gen_count < MAX_BOXES) gen_count++;
        end
    endfunction

    function automatic t_box mk_box(int x, int y, int w, int h);
        t_box b;
        b.x = POS_W'(x);
        b.y = POS_W'(y);
        b.w = SIZE_W'(w);
        b.h = SIZE_W'(h);
        return b;
    endfunction

    // Small boxes packed around the origin: hits and misses both common.
    function automatic t_box near_box();
        return mk_box(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                      $urandom_range(0, 24), $urandom_range(0, 24));
    endfunction

    function automatic t_box any_box();
        return mk_box($urandom, $urandom, $urandom, $urandom);
    endfunction

    // Query abutting the right edge of the last appended box, or one LSB inside.
    function automatic t_box edge_box();
        return mk_box(int'($signed(last_box.x)) + (int'(last_box.w) << FRAC_W)
                          - int'($urandom_range(0, 1)),
                      $signed(last_box.y), $urandom_range(0, 8), $urandom_range(1, 8));
    endfunction

    function automatic logic [OUT_IDX_W-1:0] pick_skip();
        if (gen_count == 0 || $urandom_range(0, 3) == 0) return OUT_IDX_W'($urandom_range(0, 63));
        return OUT_IDX_W'($urandom_range(0, gen_count - 1));
    endfunction

    initial begin : stimulus
        t_box q;
        int   n_app;
        int   n_q;
        int   pick;
        bit   hold;

        gen_count = 0;
        gen_items = 0;
        last_hold = 0;
        last_box  = mk_box(0, 0, 0, 0);

        // ---- directed opening ----
        add_cmd(CMD_QUERY, mk_box(-8388608, -8388608, 32767, 32767), 1'b1, 6'd63); // empty
        add_cmd(CMD_UNUSED, mk_box(8388607, 8388607, 32767, 32767), 1'b1, 6'd63);
        add_cmd(CMD_APPEND, mk_box(0, 0, 10, 10));
        add_cmd(CMD_QUERY, mk_box(0, 0, 10, 10), 1'b1, 6'd0);   // only self stored
        add_cmd(CMD_QUERY, mk_box(0, 0, 10, 10));
        add_cmd(CMD_QUERY, mk_box(2560, 0, 5, 5));              // touches right edge
        add_cmd(CMD_QUERY, mk_box(2559, 0, 5, 5));              // one LSB inside
        add_cmd(CMD_QUERY, mk_box(-1280, -1280, 5, 5));         // touches lower-left
        add_cmd(CMD_QUERY, mk_box(-1279, -1279, 5, 5));
        add_cmd(CMD_QUERY, mk_box(0, 2560, 10, 10));            // touches top edge
        add_cmd(CMD_APPEND, mk_box(-8388608, -8388608, 32767, 32767));
        add_cmd(CMD_APPEND, mk_box(8388607, 8388607, 0, 0));    // zero-size box
        add_cmd(CMD_QUERY, mk_box(8388600, 8388600, 1, 1));
        add_cmd(CMD_QUERY, mk_box(8388607, 8388607, 0, 0));     // point vs point
        add_cmd(CMD_QUERY, mk_box(-8388608, -8388608, 32767, 32767), 1'b1, 6'd1);
        add_cmd(CMD_QUERY, mk_box(-8388608, -8388608, 32767, 32767), 1'b1, 6'd63); // skip OOR
        add_cmd(CMD_QUERY, mk_box(-100, -100, 20, 20));         // hits entry 0 only
        add_cmd(CMD_QUERY, mk_box(-100, -100, 20, 20), 1'b1, 6'd1);
        add_cmd(CMD_CLEAR, mk_box(0, 0, 0, 0));
        add_cmd(CMD_QUERY, mk_box(0, 0, 10, 10));               // stale entries not seen
        add_cmd(CMD_APPEND, mk_box(100, 100, 1, 1));
        add_cmd(CMD_QUERY, mk_box(0, 0, 10, 10), 1'b0, 6'd0, 1'b1);  // sender waits idle
        add_cmd(CMD_CLEAR, mk_box(0, 0, 0, 0));

        // ---- fill to the top, overflow twice, query the full table ----
        for (int i = 0; i < MAX_BOXES + 2; i++) add_cmd(CMD_APPEND, near_box());
        add_cmd(CMD_QUERY, mk_box(-1048576, -1048576, 16384, 16384), 1'b1, 6'd63);
        add_cmd(CMD_QUERY, mk_box(-1048576, -1048576, 16384, 16384), 1'b1, 6'd0);
        add_cmd(CMD_QUERY, near_box(), 1'b0, 6'd0);

        // ---- random episodes: clear, appends, queries; noise in between ----
        while (gen_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0)
                add_cmd(CMD_UNUSED, any_box(), 1'($urandom), OUT_IDX_W'($urandom));
            if ($urandom_range(0, 3) != 0)
                add_cmd(CMD_CLEAR, any_box(), 1'($urandom), OUT_IDX_W'($urandom));
            n_app = ($urandom_range(0, 9) == 0) ? int'($urandom_range(56, 68))
                                                : int'($urandom_range(0, 10));
            for (int i = 0; i < n_app; i++) begin
                add_cmd(CMD_APPEND, ($urandom_range(0, 2) == 0) ? any_box() : near_box(),
                        1'($urandom), OUT_IDX_W'($urandom));
            end
            n_q = $urandom_range(1, 6);
            for (int i = 0; i < n_q; i++) begin
                pick = $urandom_range(0, 5);
                if (pick == 0)      q = any_box();
                else if (pick == 1) q = edge_box();
                else                q = near_box();
                // now and then the sender lets the block drain completely
                hold = (gen_items - last_hold) >= 250;
                if (hold) last_hold = gen_items;
                add_cmd(CMD_QUERY, q, 1'($urandom), pick_skip(), hold);
                if ($urandom_range(0, 4) == 0)
                    add_cmd(CMD_APPEND, near_box(), 1'($urandom), OUT_IDX_W'($urandom));
            end
        end

        // ---- wait for the backlog and all results, then a quiet tail ----
        while (cmd_backlog.size() > 0 || cmd_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() > 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));

        if (n_fail == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Hard stop: far beyond the slowest legal run (all full-table queries,
    // every gap and stall at its longest).
    initial begin : watchdog
        #(1_000_000);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/aabb_pkg.sv
rtl/aabb_if.sv
rtl/aabb_box_mem.sv
rtl/aabb_cmp.sv
rtl/aabb_overlap_scan.sv
tb/sv/tb_top.sv
